/* src/lrukv_pkg.sv */
package lrukv_pkg;

    localparam int DEFAULT_ENTRIES = 16;
    localparam int CAP_W           = 5;
    localparam int DATA_W          = 32;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
    localparam logic              CMD_GET    = 1'b0;
    localparam logic              CMD_PUT    = 1'b1;
    localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

    // Step strobes from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic compare;
        logic decide;
        logic update;
        logic cfg_write;
    } t_dp_cmd;

endpackage

/* src/lrukv_ctrl.sv */
module lrukv_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_cfg_valid,
    output logic              o_busy,
    output logic              o_cfg_ready,
    output logic              o_result_valid,
    output lrukv_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_DEC,
        ST_UPD,
        ST_RESP
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;
    logic   r_res_valid, n_res_valid;

    always_comb begin
        n_state     = r_state;
        n_busy      = r_busy;
        n_res_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_CMP;
                    n_busy  = 1'b1;
                end
            end
            ST_CMP:  n_state = ST_DEC;
            ST_DEC:  n_state = ST_UPD;
            ST_UPD: begin
                n_state     = ST_RESP;
                n_res_valid = 1'b1;
            end
            ST_RESP: begin
                n_state = ST_IDLE;
                n_busy  = 1'b0;
            end
            default: begin
                n_state = ST_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_busy      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_busy      <= n_busy;
            r_res_valid <= n_res_valid;
        end
    end

    always_comb begin
        o_cmd.capture   = (r_state == ST_IDLE) && i_start;
        o_cmd.compare   = (r_state == ST_CMP);
        o_cmd.decide    = (r_state == ST_DEC);
        o_cmd.update    = (r_state == ST_UPD);
        o_cmd.cfg_write = (r_state == ST_IDLE) && i_cfg_valid;
    end

    assign o_busy         = r_busy;
    assign o_cfg_ready    = !r_busy;
    assign o_result_valid = r_res_valid;

endmodule

/* src/lrukv_dpath.sv */
module lrukv_dpath #(
    parameter int ENTRIES = lrukv_pkg::DEFAULT_ENTRIES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lrukv_pkg::t_dp_cmd                  i_cmd,
    input  logic [lrukv_pkg::CAP_W-1:0]         i_cfg_data,
    input  logic                                i_command,
    input  logic signed [lrukv_pkg::DATA_W-1:0] i_key,
    input  logic signed [lrukv_pkg::DATA_W-1:0] i_value,
    output logic                                o_found,
    output logic signed [lrukv_pkg::DATA_W-1:0] o_read_value
);

    localparam int DW = lrukv_pkg::DATA_W;
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FW = $clog2(ENTRIES + 1);
    localparam int XW = (FW > lrukv_pkg::CAP_W) ? FW : lrukv_pkg::CAP_W;
    localparam logic [XW-1:0] ENT_X = XW'(ENTRIES);

    logic [lrukv_pkg::CAP_W-1:0] r_cap;

    logic          r_cmd;
    logic [DW-1:0] r_key;
    logic [DW-1:0] r_value;

    logic [ENTRIES-1:0] r_valid;
    logic [IW-1:0]      r_rank [ENTRIES];
    logic [FW-1:0]      r_fill;
    logic [DW-1:0]      r_keys [ENTRIES];
    logic [DW-1:0]      r_mem  [ENTRIES];
    logic [DW-1:0]      r_rd_data;

    logic [ENTRIES-1:0] r_match, n_match;
    logic [ENTRIES-1:0] r_victim, n_victim;

    logic          r_hit, n_hit;
    logic [IW-1:0] r_hit_idx, n_hit_idx;
    logic [IW-1:0] r_slot, n_slot;
    logic [IW-1:0] r_old_rank, n_old_rank;
    logic          r_age_all, n_age_all;
    logic          r_touch, n_touch;
    logic          r_wr_key, n_wr_key;
    logic          r_wr_data, n_wr_data;
    logic          r_fill_inc, n_fill_inc;

    logic [FW-1:0] fill_dec;
    logic [IW-1:0] fill_m1;
    logic [IW-1:0] hit_rank;
    logic [IW-1:0] vic_idx;
    logic [XW-1:0] cap_x, cap_s, fill_x;

    assign fill_dec = r_fill - FW'(1);
    assign fill_m1  = fill_dec[IW-1:0];

    // Every valid key compared at once; the oldest valid entry holds rank fill-1
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            n_match[i]  = r_valid[i] && (r_keys[i] == r_key);
            n_victim[i] = r_valid[i] && (r_rank[i] == fill_m1);
        end
    end

    // Valid keys are distinct, so the match vector is one-hot and an OR encodes it
    always_comb begin
        n_hit_idx = '0;
        hit_rank  = '0;
        vic_idx   = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (r_match[i]) begin
                n_hit_idx = n_hit_idx | IW'(i);
                hit_rank  = hit_rank | r_rank[i];
            end
            if (r_victim[i]) begin
                vic_idx = vic_idx | IW'(i);
            end
        end
        n_hit = |r_match;

        cap_x  = XW'(r_cap);
        cap_s  = (cap_x > ENT_X) ? ENT_X : cap_x;
        fill_x = XW'(r_fill);

        n_touch    = 1'b0;
        n_wr_key   = 1'b0;
        n_wr_data  = 1'b0;
        n_fill_inc = 1'b0;
        n_age_all  = 1'b0;
        n_slot     = n_hit_idx;
        n_old_rank = hit_rank;
        if (r_cmd == lrukv_pkg::CMD_GET) begin
            n_touch = n_hit;
        end else if (cap_s != '0) begin
            n_touch   = 1'b1;
            n_wr_data = 1'b1;
            if (!n_hit) begin
                n_wr_key = 1'b1;
                if (fill_x < cap_s) begin
                    // lowest free entry is always the one at the fill count
                    n_slot     = r_fill[IW-1:0];
                    n_age_all  = 1'b1;
                    n_fill_inc = 1'b1;
                end else begin
                    n_slot     = vic_idx;
                    n_old_rank = fill_m1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= lrukv_pkg::CAP_RESET;
        end else if (i_cmd.cfg_write) begin
            r_cap <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd   <= i_command;
            r_key   <= i_key;
            r_value <= i_value;
        end
        if (i_cmd.compare) begin
            r_match  <= n_match;
            r_victim <= n_victim;
        end
        if (i_cmd.decide) begin
            r_hit      <= n_hit;
            r_hit_idx  <= n_hit_idx;
            r_slot     <= n_slot;
            r_old_rank <= n_old_rank;
            r_age_all  <= n_age_all;
            r_touch    <= n_touch;
            r_wr_key   <= n_wr_key;
            r_wr_data  <= n_wr_data;
            r_fill_inc <= n_fill_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_fill  <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_cmd.update) begin
            if (r_touch) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (IW'(i) == r_slot) begin
                        r_rank[i] <= '0;
                    end else if (r_valid[i] && (r_age_all || (r_rank[i] < r_old_rank))) begin
                        r_rank[i] <= r_rank[i] + IW'(1);
                    end
                end
            end
            if (r_fill_inc) begin
                r_valid[r_slot] <= 1'b1;
                r_fill          <= r_fill + FW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update && r_wr_key) begin
            r_keys[r_slot] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            if (r_wr_data) begin
                r_mem[r_slot] <= r_value;
            end
            r_rd_data <= r_mem[r_hit_idx];
        end
    end

    assign o_found = r_hit;

    always_comb begin
        if (r_cmd == lrukv_pkg::CMD_PUT) begin
            o_read_value = '0;
        end else if (r_hit) begin
            o_read_value = r_rd_data;
        end else begin
            o_read_value = lrukv_pkg::MISS_VALUE;
        end
    end

endmodule

/* src/lru_key_value_cache.sv */
// Fully associative key-value cache with least-recently-used replacement.
//
// Command channel: drive i_command (get or put), i_key and i_value with start
// high; the transfer happens at a rising edge where start is high and busy is
// low. busy then stays high until the result has been presented.
// Result channel: o_found and o_read_value are valid for exactly one cycle
// while o_result_valid is high. The receiver cannot stall; the result is taken
// in that cycle or lost.
// Sequence: a command passes through compare, encode, update/read and respond,
// with the value store read through its registered port. The result is
// presented in the respond step and busy falls in the cycle after it, so a
// new command is only taken once the previous one has been answered.
// Configuration: capacity is written through i_cfg_valid / o_cfg_ready /
// i_cfg_data; o_cfg_ready is high whenever the cache is not busy.
// Reset (synchronous, active low) clears every entry's valid mark, the recency
// ranks and the fill count, and sets capacity to 16 (the default entry count).
module lru_key_value_cache #(
    parameter int ENTRIES = lrukv_pkg::DEFAULT_ENTRIES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_command,
    input  logic signed [lrukv_pkg::DATA_W-1:0] i_key,
    input  logic signed [lrukv_pkg::DATA_W-1:0] i_value,
    output logic                                o_result_valid,
    output logic                                o_found,
    output logic signed [lrukv_pkg::DATA_W-1:0] o_read_value,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lrukv_pkg::CAP_W-1:0]         i_cfg_data
);

    lrukv_pkg::t_dp_cmd dp_cmd;

    lrukv_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_cfg_valid    (i_cfg_valid),
        .o_busy         (busy),
        .o_cfg_ready    (o_cfg_ready),
        .o_result_valid (o_result_valid),
        .o_cmd          (dp_cmd)
    );

    lrukv_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .i_cfg_data   (i_cfg_data),
        .i_command    (i_command),
        .i_key        (i_key),
        .i_value      (i_value),
        .o_found      (o_found),
        .o_read_value (o_read_value)
    );

endmodule
